>>> rtl/tbw_pkg.sv
// shared constants and helper functions for the trilinear box weight pipeline
package tbw_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int INDEX_WIDTH_DEF = 16;
   localparam int COORD_W         = 32;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int LANES           = 6;
   localparam int CORNERS         = 8;
   localparam int XY_PAIRS        = 4;
   localparam int DIV_STAGES      = COORD_W + 2;
   localparam int WGT_STAGES      = 4;

   // magnitude of a signed 32-bit value, 2^31 included
   function automatic logic [COORD_W-1:0] mag32(input logic signed [COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      r = v[COORD_W-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   // saturate a sign and magnitude to signed 32 bits
   function automatic logic signed [COORD_W-1:0] sat_mag(input logic neg,
                                                          input logic [63:0] m);
      logic signed [COORD_W-1:0] r;
      if (neg) begin
         if (m >= 64'h0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
         end else begin
            r = -$signed(m[COORD_W-1:0]);
         end
      end else begin
         if (m > 64'h0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
         end else begin
            r = $signed(m[COORD_W-1:0]);
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/trilinear_box_weights.sv
// trilinear box weights: top level, 40-stage pipeline
// an accepted transaction's result leaves the last stage on rsp_valid
// throughput: one transaction per cycle while rsp_stall does not hold the pipeline; set by the 32-step divider pipeline
// stages only hold while full and blocked downstream, so bubbles close up
// reset (synchronous, active high) clears all valid bits and element_count
// csr writes are always taken (csr_ready high)
module trilinear_box_weights import tbw_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [INDEX_WIDTH:0]      csr_element_count,
   // query transactions
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [INDEX_WIDTH-1:0]    req_element_index,
   input  logic signed [COORD_W-1:0] req_x_low,
   input  logic signed [COORD_W-1:0] req_x_high,
   input  logic signed [COORD_W-1:0] req_y_low,
   input  logic signed [COORD_W-1:0] req_y_high,
   input  logic signed [COORD_W-1:0] req_z_low,
   input  logic signed [COORD_W-1:0] req_z_high,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_point_z,
   // result transactions
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_weight_0,
   output logic signed [COORD_W-1:0] rsp_weight_1,
   output logic signed [COORD_W-1:0] rsp_weight_2,
   output logic signed [COORD_W-1:0] rsp_weight_3,
   output logic signed [COORD_W-1:0] rsp_weight_4,
   output logic signed [COORD_W-1:0] rsp_weight_5,
   output logic signed [COORD_W-1:0] rsp_weight_6,
   output logic signed [COORD_W-1:0] rsp_weight_7,
   output logic                      rsp_point_inside,
   output logic                      rsp_index_error,
   output logic                      rsp_degenerate_cell
);

   // stage map: 0 differences, 1 magnitudes, 2..35 divider, 36..39 products
   localparam int DIV_BASE = 2;
   localparam int WGT_BASE = DIV_BASE + DIV_STAGES;
   localparam int NSTAGES  = WGT_BASE + WGT_STAGES;

   logic [INDEX_WIDTH:0] count_ff;

   logic [NSTAGES-1:0]   v_ff;
   logic [NSTAGES-1:0]   en;
   logic                 ierr_ff  [0:NSTAGES-1];
   logic                 degen_ff [0:NSTAGES-1];
   logic                 ierr_in, degen_in;

   // lane order: dx0, dx1, dy0, dy1, dz0, dz1
   logic signed [DIFF_W-1:0] num_in [0:LANES-1];
   logic signed [DIFF_W-1:0] den_in [0:LANES-1];
   logic signed [DIFF_W-1:0] num_ff [0:LANES-1];
   logic signed [DIFF_W-1:0] den_ff [0:LANES-1];
   logic [DIFF_W-1:0]        nmag_ff [0:LANES-1];
   logic [DIFF_W-1:0]        dmag_ff [0:LANES-1];
   logic                     neg_ff  [0:LANES-1];
   logic signed [COORD_W-1:0] quo   [0:LANES-1];
   logic signed [COORD_W-1:0] weight [0:CORNERS-1];
   logic                      in_box;

   function automatic logic signed [DIFF_W-1:0] sub33(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
      logic signed [DIFF_W-1:0] r;
      r = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return r;
   endfunction

   function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] r;
      r = v[DIFF_W-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   // configuration register; the user writes it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_element_count;
      end
   end

   // a stage moves when empty or when the stage after it moves
   always_comb begin
      en[NSTAGES-1] = !v_ff[NSTAGES-1] || !rsp_stall;
      for (int k = NSTAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // status flags and lane differences; the flags ride alongside the data
   always_comb begin
      ierr_in  = {1'b0, req_element_index} >= count_ff;
      degen_in = (req_x_high == req_x_low) || (req_y_high == req_y_low) ||
                 (req_z_high == req_z_low);
      num_in[0] = sub33(req_point_x, req_x_low);
      num_in[1] = sub33(req_x_high, req_point_x);
      num_in[2] = sub33(req_point_y, req_y_low);
      num_in[3] = sub33(req_y_high, req_point_y);
      num_in[4] = sub33(req_point_z, req_z_low);
      num_in[5] = sub33(req_z_high, req_point_z);
      den_in[0] = sub33(req_x_high, req_x_low);
      den_in[1] = den_in[0];
      den_in[2] = sub33(req_y_high, req_y_low);
      den_in[3] = den_in[2];
      den_in[4] = sub33(req_z_high, req_z_low);
      den_in[5] = den_in[4];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ierr_ff[0]  <= ierr_in;
         degen_ff[0] <= degen_in;
         num_ff      <= num_in;
         den_ff      <= den_in;
      end
      if (en[1]) begin
         for (int l = 0; l < LANES; l++) begin
            nmag_ff[l] <= mag33(num_ff[l]);
            dmag_ff[l] <= mag33(den_ff[l]);
            neg_ff[l]  <= num_ff[l][DIFF_W-1] ^ den_ff[l][DIFF_W-1];
         end
      end
      for (int k = 1; k < NSTAGES; k++) begin
         if (en[k]) begin
            ierr_ff[k]  <= ierr_ff[k-1];
            degen_ff[k] <= degen_ff[k-1];
         end
      end
   end

   // six offset quotients in parallel; a zero-width axis gives junk, masked later
   for (genvar l = 0; l < LANES; l++) begin : g_div
      tbw_divider #(
         .FRAC_BITS (FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .en      (en[DIV_BASE +: DIV_STAGES]),
         .num_mag (nmag_ff[l]),
         .den_mag (dmag_ff[l]),
         .neg     (neg_ff[l]),
         .quo     (quo[l])
      );
   end

   tbw_weight #(
      .FRAC_BITS (FRAC_BITS)
   ) u_weight (
      .clock  (clock),
      .en     (en[WGT_BASE +: WGT_STAGES]),
      .dx0    (quo[0]),
      .dx1    (quo[1]),
      .dy0    (quo[2]),
      .dy1    (quo[3]),
      .dz0    (quo[4]),
      .dz1    (quo[5]),
      .kill   (ierr_ff[WGT_BASE-1] || degen_ff[WGT_BASE-1]),
      .weight (weight),
      .in_box (in_box)
   );

   assign rsp_valid           = v_ff[NSTAGES-1];
   assign rsp_weight_0        = weight[0];
   assign rsp_weight_1        = weight[1];
   assign rsp_weight_2        = weight[2];
   assign rsp_weight_3        = weight[3];
   assign rsp_weight_4        = weight[4];
   assign rsp_weight_5        = weight[5];
   assign rsp_weight_6        = weight[6];
   assign rsp_weight_7        = weight[7];
   assign rsp_point_inside    = in_box;
   assign rsp_index_error     = ierr_ff[NSTAGES-1];
   assign rsp_degenerate_cell = degen_ff[NSTAGES-1];

endmodule

>>> rtl/tbw_divider.sv
// pipelined restoring divider, one quotient bit per stage, saturated q.f result
module tbw_divider import tbw_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic [DIV_STAGES-1:0]      en,
   input  logic [DIFF_W-1:0]          num_mag,
   input  logic [DIFF_W-1:0]          den_mag,
   input  logic                       neg,
   output logic signed [COORD_W-1:0]  quo
);

   localparam int SHIFT = COORD_W - FRAC_BITS;
   localparam int CW    = DIFF_W + SHIFT;
   localparam int NW    = DIFF_W + FRAC_BITS;

   logic [DIFF_W-1:0]  r_ff   [0:COORD_W-1];
   logic [DIFF_W-1:0]  d_ff   [0:COORD_W-1];
   logic [COORD_W-1:0] low_ff [0:COORD_W-1];
   logic [COORD_W-1:0] q_ff   [0:COORD_W];
   logic               neg_ff [0:COORD_W];
   logic               ovf_ff [0:COORD_W];
   logic signed [COORD_W-1:0] quo_ff;
   logic [NW-1:0]      nshift;
   logic               ovf_in;

   always_comb begin
      nshift = NW'(num_mag) << FRAC_BITS;
      ovf_in = CW'(num_mag) >= (CW'(den_mag) << SHIFT);
   end

   // quotient of 2^32 or more always saturates
   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0]   <= DIFF_W'(num_mag >> SHIFT);
         d_ff[0]   <= den_mag;
         low_ff[0] <= nshift[COORD_W-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar s = 1; s <= COORD_W; s++) begin : g_step
      logic [DIFF_W:0] t;
      logic            ge;
      always_comb begin
         t  = {r_ff[s-1], low_ff[s-1][COORD_W-1]};
         ge = t >= {1'b0, d_ff[s-1]};
      end
      always_ff @(posedge clock) begin
         if (en[s]) begin
            q_ff[s]   <= {q_ff[s-1][COORD_W-2:0], ge};
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
      if (s < COORD_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (en[s]) begin
               r_ff[s]   <= ge ? DIFF_W'(t - {1'b0, d_ff[s-1]}) : t[DIFF_W-1:0];
               d_ff[s]   <= d_ff[s-1];
               low_ff[s] <= {low_ff[s-1][COORD_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[DIV_STAGES-1]) begin
         quo_ff <= sat_mag(neg_ff[COORD_W],
                           ovf_ff[COORD_W] ? '1 : {32'd0, q_ff[COORD_W]});
      end
   end

   assign quo = quo_ff;

endmodule

>>> rtl/tbw_weight.sv
// corner weight products: x*y, then *z, each product saturated in its own stage
module tbw_weight import tbw_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic [WGT_STAGES-1:0]     en,
   input  logic signed [COORD_W-1:0] dx0,
   input  logic signed [COORD_W-1:0] dx1,
   input  logic signed [COORD_W-1:0] dy0,
   input  logic signed [COORD_W-1:0] dy1,
   input  logic signed [COORD_W-1:0] dz0,
   input  logic signed [COORD_W-1:0] dz1,
   input  logic                      kill,
   output logic signed [COORD_W-1:0] weight [0:CORNERS-1],
   output logic                      in_box
);

   logic signed [COORD_W-1:0] xa [0:XY_PAIRS-1];
   logic signed [COORD_W-1:0] ya [0:XY_PAIRS-1];
   logic [63:0]               pxy_ff [0:XY_PAIRS-1];
   logic                      nxy_ff [0:XY_PAIRS-1];
   logic signed [COORD_W-1:0] xy_ff  [0:XY_PAIRS-1];
   logic signed [COORD_W-1:0] z0_a_ff, z1_a_ff, z0_b_ff, z1_b_ff;
   logic                      kill_ff [0:WGT_STAGES-2];
   logic [63:0]               p_ff   [0:CORNERS-1];
   logic                      n_ff   [0:CORNERS-1];
   logic signed [COORD_W-1:0] w_ff   [0:CORNERS-1];
   logic signed [COORD_W-1:0] w_in   [0:CORNERS-1];
   logic                      inside_ff, inside_in;

   // pair order: x1y1, x0y1, x0y0, x1y0 matches corners 0..3
   always_comb begin
      xa[0] = dx1; ya[0] = dy1;
      xa[1] = dx0; ya[1] = dy1;
      xa[2] = dx0; ya[2] = dy0;
      xa[3] = dx1; ya[3] = dy0;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < XY_PAIRS; i++) begin
            pxy_ff[i] <= 64'(mag32(xa[i])) * 64'(mag32(ya[i]));
            nxy_ff[i] <= xa[i][COORD_W-1] ^ ya[i][COORD_W-1];
         end
         z0_a_ff    <= dz0;
         z1_a_ff    <= dz1;
         kill_ff[0] <= kill;
      end
      if (en[1]) begin
         for (int i = 0; i < XY_PAIRS; i++) begin
            xy_ff[i] <= sat_mag(nxy_ff[i], pxy_ff[i] >> FRAC_BITS);
         end
         z0_b_ff    <= z0_a_ff;
         z1_b_ff    <= z1_a_ff;
         kill_ff[1] <= kill_ff[0];
      end
      if (en[2]) begin
         for (int i = 0; i < XY_PAIRS; i++) begin
            p_ff[i]            <= 64'(mag32(xy_ff[i])) * 64'(mag32(z1_b_ff));
            n_ff[i]            <= xy_ff[i][COORD_W-1] ^ z1_b_ff[COORD_W-1];
            p_ff[i+XY_PAIRS]   <= 64'(mag32(xy_ff[i])) * 64'(mag32(z0_b_ff));
            n_ff[i+XY_PAIRS]   <= xy_ff[i][COORD_W-1] ^ z0_b_ff[COORD_W-1];
         end
         kill_ff[2] <= kill_ff[1];
      end
   end

   always_comb begin
      inside_in = !kill_ff[2];
      for (int i = 0; i < CORNERS; i++) begin
         w_in[i] = kill_ff[2] ? '0 : sat_mag(n_ff[i], p_ff[i] >> FRAC_BITS);
         if (w_in[i][COORD_W-1]) begin
            inside_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         w_ff      <= w_in;
         inside_ff <= inside_in;
      end
   end

   assign weight = w_ff;
   assign in_box = inside_ff;

endmodule

>>> test/tb_top.sv
// testbench for trilinear_box_weights: queued driver, monitor and fixed-point predictor
`timescale 1ns / 1ps

module tb_top;
   import tbw_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int IW = INDEX_WIDTH_DEF;
   localparam int LATENCY = 40;

   typedef struct packed {
      logic [IW-1:0] idx;
      logic signed [31:0] xl, xh, yl, yh, zl, zh, px, py, pz;
   } query_type;

   typedef struct packed {
      logic signed [31:0] w0, w1, w2, w3, w4, w5, w6, w7;
      logic in_box, idx_err, degen;
   } weights_type;

   logic clock = 0, reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [IW:0] csr_element_count = '0;
   logic req_valid = 0, req_stall;
   logic [IW-1:0] req_element_index = '0;
   logic signed [31:0] req_x_low = 0, req_x_high = 0, req_y_low = 0, req_y_high = 0;
   logic signed [31:0] req_z_low = 0, req_z_high = 0, req_point_x = 0, req_point_y = 0;
   logic signed [31:0] req_point_z = 0;
   logic rsp_valid, rsp_stall = 0;
   logic signed [31:0] rsp_weight_0, rsp_weight_1, rsp_weight_2, rsp_weight_3;
   logic signed [31:0] rsp_weight_4, rsp_weight_5, rsp_weight_6, rsp_weight_7;
   logic rsp_point_inside, rsp_index_error, rsp_degenerate_cell;

   trilinear_box_weights DUT (.*);

   // pending queries, expected weight sets, and the predictor's copy of the register
   query_type pending_queries[$];
   weights_type expected_weights[$];
   logic [IW:0] model_count = '0;
   int errors = 0, accepted = 0, received = 0;
   int n_inside = 0, n_idx_err = 0, n_degen = 0;
   bit quiet = 0;          // no idling in the last part of the run
   bit hold_req = 0;       // asks the receiver for one long hold-off

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void add_query(input query_type q);
      pending_queries = {pending_queries, q};
   endfunction

   // signed saturation from a sign and a magnitude
   function automatic logic signed [31:0] clamp32(input bit neg, input logic [63:0] m);
      if (neg) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed({1'b0, m[31:0]});
      return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // offset quotient, truncated toward zero
   function automatic logic signed [31:0] offset_div(input logic signed [63:0] num,
                                                     input logic signed [63:0] den);
      logic [63:0] q;
      q = (abs64(num) << FB) / abs64(den);
      return clamp32((num < 0) != (den < 0), q);
   endfunction

   function automatic logic signed [31:0] offset_mul(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
      logic [63:0] p;
      p = (abs64(a) * abs64(b)) >> FB;
      return clamp32((a < 0) != (b < 0), p);
   endfunction

   function automatic weights_type predict_weights(input query_type q);
      weights_type r;
      logic signed [63:0] xl, xh, yl, yh, zl, zh, px, py, pz;
      logic signed [31:0] dx0, dx1, dy0, dy1, dz0, dz1;
      r = '0;
      xl = q.xl; xh = q.xh; yl = q.yl; yh = q.yh; zl = q.zl; zh = q.zh;
      px = q.px; py = q.py; pz = q.pz;
      r.idx_err = {1'b0, q.idx} >= model_count;
      r.degen = (xh == xl) || (yh == yl) || (zh == zl);
      if (!r.idx_err && !r.degen) begin
         dx0 = offset_div(px - xl, xh - xl);
         dx1 = offset_div(xh - px, xh - xl);
         dy0 = offset_div(py - yl, yh - yl);
         dy1 = offset_div(yh - py, yh - yl);
         dz0 = offset_div(pz - zl, zh - zl);
         dz1 = offset_div(zh - pz, zh - zl);
         r.w0 = offset_mul(offset_mul(dx1, dy1), dz1);
         r.w1 = offset_mul(offset_mul(dx0, dy1), dz1);
         r.w2 = offset_mul(offset_mul(dx0, dy0), dz1);
         r.w3 = offset_mul(offset_mul(dx1, dy0), dz1);
         r.w4 = offset_mul(offset_mul(dx1, dy1), dz0);
         r.w5 = offset_mul(offset_mul(dx0, dy1), dz0);
         r.w6 = offset_mul(offset_mul(dx0, dy0), dz0);
         r.w7 = offset_mul(offset_mul(dx1, dy0), dz0);
         r.in_box = !(r.w0 < 0 || r.w1 < 0 || r.w2 < 0 || r.w3 < 0 ||
                      r.w4 < 0 || r.w5 < 0 || r.w6 < 0 || r.w7 < 0);
      end
      return r;
   endfunction

   // acceptance flag captured at the rising edge, used by the driver
   logic req_taken = 0;

   // driver: presents the head of the queue, keeps it stable while stalled
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 0;
            end else if (pending_queries.size() > 0) begin
               query_type q;
               q = pending_queries.pop_front();
               req_valid <= 1;
               req_element_index <= q.idx;
               req_x_low <= q.xl; req_x_high <= q.xh;
               req_y_low <= q.yl; req_y_high <= q.yh;
               req_z_low <= q.zl; req_z_high <= q.zh;
               req_point_x <= q.px; req_point_y <= q.py; req_point_z <= q.pz;
               if (!quiet && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 19);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_weights = {expected_weights, predict_weights({req_element_index,
            req_x_low, req_x_high, req_y_low, req_y_high, req_z_low, req_z_high,
            req_point_x, req_point_y, req_point_z})};
         accepted <= accepted + 1;
      end
   end

   // receiver stall: random bursts, plus one long hold-off counted here
   int stall_left = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_req && hold_left == 0) begin
         hold_left <= 300;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // monitor: compares each result transaction against the oldest expectation
   always @(posedge clock) begin
      weights_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_weight_0, rsp_weight_1, rsp_weight_2, rsp_weight_3, rsp_weight_4,
                rsp_weight_5, rsp_weight_6, rsp_weight_7, rsp_point_inside,
                rsp_index_error, rsp_degenerate_cell};
         received <= received + 1;
         if (expected_weights.size() == 0) begin
            $display("%0t: unexpected result transaction, exp none got %h", $realtime, got);
            errors <= errors + 1;
         end else begin
            want = expected_weights.pop_front();
            if (got.in_box) n_inside <= n_inside + 1;
            if (got.idx_err) n_idx_err <= n_idx_err + 1;
            if (got.degen) n_degen <= n_degen + 1;
            if (got.w0 !== want.w0) $display("%0t: weight_0 exp %h got %h", $realtime, want.w0, got.w0);
            if (got.w1 !== want.w1) $display("%0t: weight_1 exp %h got %h", $realtime, want.w1, got.w1);
            if (got.w2 !== want.w2) $display("%0t: weight_2 exp %h got %h", $realtime, want.w2, got.w2);
            if (got.w3 !== want.w3) $display("%0t: weight_3 exp %h got %h", $realtime, want.w3, got.w3);
            if (got.w4 !== want.w4) $display("%0t: weight_4 exp %h got %h", $realtime, want.w4, got.w4);
            if (got.w5 !== want.w5) $display("%0t: weight_5 exp %h got %h", $realtime, want.w5, got.w5);
            if (got.w6 !== want.w6) $display("%0t: weight_6 exp %h got %h", $realtime, want.w6, got.w6);
            if (got.w7 !== want.w7) $display("%0t: weight_7 exp %h got %h", $realtime, want.w7, got.w7);
            if (got.in_box !== want.in_box)
               $display("%0t: point_inside exp %b got %b", $realtime, want.in_box, got.in_box);
            if (got.idx_err !== want.idx_err)
               $display("%0t: index_error exp %b got %b", $realtime, want.idx_err, got.idx_err);
            if (got.degen !== want.degen)
               $display("%0t: degenerate_cell exp %b got %b", $realtime, want.degen, got.degen);
            if (got !== want) errors <= errors + 1;
         end
      end
   end

   // random coordinate: mostly moderate, sometimes any 32-bit value
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
   endfunction

   // well-formed box with the point mostly inside, occasionally degenerate or inverted
   function automatic query_type rand_query(input int idx_lim);
      query_type q;
      logic signed [31:0] ext;
      q.idx = IW'((idx_lim > 0 && $urandom_range(0, 9) != 0) ?
                  $urandom_range(0, idx_lim - 1) : $urandom());
      if ($urandom_range(0, 7) == 0) begin
         q.xl = $urandom(); q.xh = $urandom(); q.yl = $urandom(); q.yh = $urandom();
         q.zl = $urandom(); q.zh = $urandom(); q.px = $urandom(); q.py = $urandom();
         q.pz = $urandom();
      end else begin
         q.xl = rand_coord(); ext = $urandom_range(1, 32'h0010_0000);
         q.xh = q.xl + ext; q.px = q.xl + $signed($urandom_range(0, ext));
         q.yl = rand_coord(); ext = $urandom_range(1, 32'h0010_0000);
         q.yh = q.yl + ext; q.py = q.yl + $signed($urandom_range(0, ext));
         q.zl = rand_coord(); ext = $urandom_range(1, 32'h0010_0000);
         q.zh = q.zl + ext; q.pz = q.zl + $signed($urandom_range(0, ext));
         if ($urandom_range(0, 9) == 0) q.px = rand_coord();
         if ($urandom_range(0, 19) == 0) q.yh = q.yl;
         if ($urandom_range(0, 19) == 0) {q.zl, q.zh} = {q.zh, q.zl};
      end
      return q;
   endfunction

   task automatic write_count(input logic [IW:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_element_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_count = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // wait for every result, then for the pipeline depth
   task automatic drain();
      while (pending_queries.size() > 0 || req_valid || expected_weights.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic run_random(input int n, input int idx_lim);
      for (int i = 0; i < n; i++) add_query(rand_query(idx_lim));
      drain();
   endtask

   initial begin
      query_type q;
      logic [IW:0] counts[5];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset count of zero makes every index an error
      q = '{idx: 0, xl: 0, xh: 32'sh0001_0000, yl: 0, yh: 32'sh0001_0000, zl: 0,
            zh: 32'sh0001_0000, px: 32'sh0000_8000, py: 32'sh0000_8000, pz: 32'sh0000_8000};
      add_query(q);
      drain();
      write_count(17'h10000);
      add_query(q);
      q.idx = 16'hFFFF; add_query(q);                            // top index, in range
      q.idx = 3; q.px = 0; q.py = 0; q.pz = 0; add_query(q);     // corner
      q.px = 32'sh0001_0000; q.py = 32'sh0001_0000; q.pz = 32'sh0001_0000;
      add_query(q);
      q.px = 32'sh0002_0000; add_query(q);                       // outside
      q.xh = 0; add_query(q);                                    // zero-width x
      q.xh = 32'sh0001_0000; q.zh = 0; add_query(q);             // zero-width z
      q.zh = 32'sh0001_0000; q.xl = 32'sh0001_0000; q.xh = 0;   // inverted x
      q.px = 32'sh0000_4000; add_query(q);
      q = '{idx: 1, xl: 32'sh8000_0000, xh: 32'sh7FFF_FFFF, yl: 32'sh8000_0000,
            yh: 32'sh7FFF_FFFF, zl: 32'sh8000_0000, zh: 32'sh7FFF_FFFF,
            px: 32'sh7FFF_FFFF, py: 32'sh8000_0000, pz: 0};
      add_query(q);
      q = '{idx: 2, xl: 0, xh: 1, yl: 0, yh: 1, zl: 0, zh: 1,       // tiny box, saturation
            px: 32'sh8000_0000, py: 32'sh7FFF_FFFF, pz: 32'sh7FFF_FFFF};
      add_query(q);
      q.xl = 32'sh7FFF_FFFF; q.xh = 32'sh8000_0000; q.px = 0; add_query(q);
      drain();

      // long receiver hold-off while the sender keeps offering queries
      for (int i = 0; i < 120; i++) add_query(rand_query(17'h10000));
      hold_req = 1;
      wait (hold_left > 0);
      hold_req = 0;
      drain();

      counts = '{17'd1, 17'd1000, 17'h1FFFF, 17'd0, 17'd40000};
      foreach (counts[k]) begin
         write_count(counts[k]);
         run_random(220, model_count > 17'h10000 ? 17'h10000 : model_count);
      end
      write_count(17'h10000);
      quiet = 1;
      run_random(220, 17'h10000);

      $display("sent %0d queries, checked %0d results: %0d inside, %0d index errors,",
               accepted, received, n_inside, n_idx_err);
      $display("%0d degenerate cells, across several element counts and a long stall",
               n_degen);
      if (errors == 0) begin
         $display("trilinear_box_weights regression: pass");
      end else begin
         $display("trilinear_box_weights regression: fail");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("trilinear_box_weights regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/tbw_pkg.sv
rtl/tbw_divider.sv
rtl/tbw_weight.sv
rtl/trilinear_box_weights.sv
test/tb_top.sv
